### hw/rtl/two_door_hysteresis_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-door hysteresis controller
// Clocked concurrent assertions with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef TWO_DOOR_HYSTERESIS_CONTROLLER_TOP_ASSERT_SVH
`define TWO_DOOR_HYSTERESIS_CONTROLLER_TOP_ASSERT_SVH

// assertion on the rising clock edge, disabled while reset is low
`define THDC_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("thdc assertion failed");

// assertion on the rising clock edge, always checked
`define THDC_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("thdc assertion failed");

`endif

### hw/rtl/thdc_pkg.sv
// ----------------------------------------------------------------------------
// thdc_pkg
// Types, codes and constants shared by the two-door hysteresis controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package thdc_pkg;

    typedef logic [1:0]        t_op;
    typedef logic signed [11:0] t_temp;
    typedef logic [3:0]        t_cmd;
    typedef logic [1:0]        t_drive;
    typedef logic [1:0]        t_event;
    typedef logic [9:0]        t_band;
    typedef logic [7:0]        t_secs;
    typedef logic [1:0]        t_cfg_idx;
    typedef logic [11:0]       t_cfg_data;

    // item kinds
    localparam t_op OP_TEMP = 2'd0;
    localparam t_op OP_CMD  = 2'd1;
    localparam t_op OP_TICK = 2'd2;

    // commands
    localparam t_cmd CMD_OPEN_A   = 4'd0;
    localparam t_cmd CMD_OPEN_B   = 4'd1;
    localparam t_cmd CMD_STOP_A   = 4'd2;
    localparam t_cmd CMD_STOP_B   = 4'd3;
    localparam t_cmd CMD_CLOSE_A  = 4'd4;
    localparam t_cmd CMD_CLOSE_B  = 4'd5;
    localparam t_cmd CMD_MODE     = 4'd6;
    localparam t_cmd CMD_TOGGLE_A = 4'd7;
    localparam t_cmd CMD_TOGGLE_B = 4'd8;

    // motor drive
    localparam t_drive DRV_STOP  = 2'd0;
    localparam t_drive DRV_OPEN  = 2'd1;
    localparam t_drive DRV_CLOSE = 2'd2;

    // door events
    localparam t_event EV_NONE   = 2'd0;
    localparam t_event EV_OPENED = 2'd1;
    localparam t_event EV_CLOSED = 2'd2;

    // register indexes
    localparam t_cfg_idx REG_LEVEL_A = 2'd0;
    localparam t_cfg_idx REG_LEVEL_B = 2'd1;
    localparam t_cfg_idx REG_BAND    = 2'd2;
    localparam t_cfg_idx REG_RUN     = 2'd3;

    // register reset values
    localparam t_temp RST_LEVEL_A = 12'sd416;
    localparam t_temp RST_LEVEL_B = 12'sd400;
    localparam t_band RST_BAND    = 10'd16;
    localparam t_secs RST_RUN     = 8'd20;

    typedef struct packed {
        logic   is_open;
        logic   running;
        t_drive drive;
    } t_door_st;

    typedef struct packed {
        logic do_open;
        logic do_close;
        logic do_stop;
        logic do_toggle;
        logic timer_fire;
        logic auto_en;
    } t_door_ctl;

endpackage

### hw/rtl/thdc_in_if.sv
// ----------------------------------------------------------------------------
// thdc_in_if
// Input channel: temperature sample, command or tick transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface thdc_in_if;
    logic              valid;
    logic              ready;
    thdc_pkg::t_op     op;
    thdc_pkg::t_temp   temperature;
    thdc_pkg::t_cmd    command;

    modport source (output valid, output op, output temperature, output command,
                    input ready);
    modport sink   (input valid, input op, input temperature, input command,
                    output ready);
endinterface

### hw/rtl/thdc_out_if.sv
// ----------------------------------------------------------------------------
// thdc_out_if
// Result channel: motor drives, door flags, mode and events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface thdc_out_if;
    logic              valid;
    logic              ready;
    thdc_pkg::t_drive  motor_a_drive;
    thdc_pkg::t_drive  motor_b_drive;
    logic              door_a_open;
    logic              door_b_open;
    logic              manual_mode;
    thdc_pkg::t_event  event_a;
    thdc_pkg::t_event  event_b;

    modport source (output valid, output motor_a_drive, output motor_b_drive,
                    output door_a_open, output door_b_open, output manual_mode,
                    output event_a, output event_b, input ready);
    modport sink   (input valid, input motor_a_drive, input motor_b_drive,
                    input door_a_open, input door_b_open, input manual_mode,
                    input event_a, input event_b, output ready);
endinterface

### hw/rtl/thdc_door.sv
// ----------------------------------------------------------------------------
// thdc_door
// Next state of one door: command, timer stop, then hysteresis checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thdc_door (
    input  thdc_pkg::t_door_st  i_st,
    input  thdc_pkg::t_door_ctl i_ctl,
    input  thdc_pkg::t_temp     i_temp,
    input  thdc_pkg::t_temp     i_level,
    input  thdc_pkg::t_band     i_band,
    output thdc_pkg::t_door_st  o_st,
    output thdc_pkg::t_event    o_event
);
    import thdc_pkg::*;

    logic signed [13:0] temp_x;
    logic signed [13:0] level_x;
    logic signed [13:0] band_x;
    logic signed [13:0] hi_thr;
    logic signed [13:0] lo_thr;
    logic               at_hi;
    logic               at_lo;

    assign temp_x  = 14'(i_temp);
    assign level_x = 14'(i_level);
    assign band_x  = $signed({4'd0, i_band});
    assign hi_thr  = level_x + band_x;
    assign lo_thr  = level_x - band_x;
    assign at_hi   = temp_x >= hi_thr;
    assign at_lo   = temp_x <= lo_thr;

    always_comb begin
        o_st    = i_st;
        o_event = EV_NONE;

        if (i_ctl.do_open || (i_ctl.do_toggle && !i_st.is_open)) begin
            o_st    = '{is_open: 1'b1, running: 1'b1, drive: DRV_OPEN};
            o_event = EV_OPENED;
        end else if (i_ctl.do_close || (i_ctl.do_toggle && i_st.is_open)) begin
            o_st    = '{is_open: 1'b0, running: 1'b1, drive: DRV_CLOSE};
            o_event = EV_CLOSED;
        end else if (i_ctl.do_stop) begin
            o_st.drive = DRV_STOP;
        end

        if (i_ctl.timer_fire && o_st.running) begin
            o_st.running = 1'b0;
            o_st.drive   = DRV_STOP;
        end

        if (i_ctl.auto_en) begin
            if (at_hi && !o_st.is_open) begin
                o_st    = '{is_open: 1'b1, running: 1'b1, drive: DRV_OPEN};
                o_event = EV_OPENED;
            end
            if (at_lo && o_st.is_open) begin
                o_st    = '{is_open: 1'b0, running: 1'b1, drive: DRV_CLOSE};
                o_event = EV_CLOSED;
            end
        end
    end

endmodule

### hw/rtl/two_door_hysteresis_controller_top.sv
// ----------------------------------------------------------------------------
// two_door_hysteresis_controller_top
// Two door motors driven by commands, a run timer and temperature hysteresis.
// ----------------------------------------------------------------------------
//   channel   | dir | transaction
//   i_in      | in  | op, temperature, command
//   o_out     | out | motor drives, door flags, manual mode, door events
//   i_cfg_*   | in  | register write: index, data (no handshake)
//
// One transaction per cycle sustained while results are taken; an accepted input
// passes the input register, then the result register, before its result is valid.
// The door state updates in the same cycle the result register loads.
// Reset is synchronous: state, registers and valids take their reset values.
// A stalled result holds; one more input transaction is buffered behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_door_hysteresis_controller_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    thdc_in_if.sink              i_in,
    thdc_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  thdc_pkg::t_cfg_idx   i_cfg_idx,
    input  thdc_pkg::t_cfg_data  i_cfg_data
);
    import thdc_pkg::*;

    // configuration
    t_temp     r_level_a;
    t_temp     r_level_b;
    t_band     r_band;
    t_secs     r_run;

    // input register
    logic      r_in_valid;
    t_op       r_in_op;
    t_temp     r_in_temp;
    t_cmd      r_in_cmd;

    // state
    t_temp     r_last_temp;
    t_door_st  r_door_a;
    t_door_st  r_door_b;
    logic      r_manual;
    t_secs     r_tick;

    // result register
    logic      r_out_valid;
    t_door_st  r_out_a;
    t_door_st  r_out_b;
    logic      r_out_manual;
    t_event    r_out_ev_a;
    t_event    r_out_ev_b;

    logic      advance;
    logic      fire;
    t_temp     n_last_temp;
    logic      n_manual;
    t_secs     n_tick;
    t_secs     tick_inc;
    logic      timer_fire;
    logic      is_cmd;
    t_door_ctl ctl_a;
    t_door_ctl ctl_b;
    t_door_st  n_door_a;
    t_door_st  n_door_b;
    t_event    ev_a;
    t_event    ev_b;

    assign advance    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || advance;
    assign fire       = r_in_valid && advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_a <= RST_LEVEL_A;
            r_level_b <= RST_LEVEL_B;
            r_band    <= RST_BAND;
            r_run     <= RST_RUN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEVEL_A: r_level_a <= $signed(i_cfg_data);
                REG_LEVEL_B: r_level_b <= $signed(i_cfg_data);
                REG_BAND:    r_band    <= i_cfg_data[9:0];
                REG_RUN:     r_run     <= i_cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.op;
            r_in_temp <= i_in.temperature;
            r_in_cmd  <= i_in.command;
        end
    end

    // item decode
    assign is_cmd      = r_in_op == OP_CMD;
    assign n_last_temp = (r_in_op == OP_TEMP) ? r_in_temp : r_last_temp;
    assign n_manual    = r_manual ^ (is_cmd && r_in_cmd == CMD_MODE);
    assign tick_inc    = r_tick + 8'd1;
    assign timer_fire  = (r_in_op == OP_TICK) && (tick_inc >= r_run);

    always_comb begin
        if (r_in_op == OP_TICK) begin
            n_tick = timer_fire ? '0 : tick_inc;
        end else begin
            n_tick = r_tick;
        end
    end

    assign ctl_a = '{
        do_open:    is_cmd && r_in_cmd == CMD_OPEN_A,
        do_close:   is_cmd && r_in_cmd == CMD_CLOSE_A,
        do_stop:    is_cmd && r_in_cmd == CMD_STOP_A,
        do_toggle:  is_cmd && r_in_cmd == CMD_TOGGLE_A,
        timer_fire: timer_fire,
        auto_en:    !n_manual
    };

    assign ctl_b = '{
        do_open:    is_cmd && r_in_cmd == CMD_OPEN_B,
        do_close:   is_cmd && r_in_cmd == CMD_CLOSE_B,
        do_stop:    is_cmd && r_in_cmd == CMD_STOP_B,
        do_toggle:  is_cmd && r_in_cmd == CMD_TOGGLE_B,
        timer_fire: timer_fire,
        auto_en:    !n_manual
    };

    thdc_door u_door_a (
        .i_st    (r_door_a),
        .i_ctl   (ctl_a),
        .i_temp  (n_last_temp),
        .i_level (r_level_a),
        .i_band  (r_band),
        .o_st    (n_door_a),
        .o_event (ev_a)
    );

    thdc_door u_door_b (
        .i_st    (r_door_b),
        .i_ctl   (ctl_b),
        .i_temp  (n_last_temp),
        .i_level (r_level_b),
        .i_band  (r_band),
        .o_st    (n_door_b),
        .o_event (ev_b)
    );

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_temp <= '0;
            r_door_a    <= '{is_open: 1'b0, running: 1'b1, drive: DRV_STOP};
            r_door_b    <= '{is_open: 1'b0, running: 1'b1, drive: DRV_STOP};
            r_manual    <= 1'b0;
            r_tick      <= '0;
        end else if (fire) begin
            r_last_temp <= n_last_temp;
            r_door_a    <= n_door_a;
            r_door_b    <= n_door_b;
            r_manual    <= n_manual;
            r_tick      <= n_tick;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_a      <= n_door_a;
            r_out_b      <= n_door_b;
            r_out_manual <= n_manual;
            r_out_ev_a   <= ev_a;
            r_out_ev_b   <= ev_b;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.motor_a_drive = r_out_a.drive;
    assign o_out.motor_b_drive = r_out_b.drive;
    assign o_out.door_a_open   = r_out_a.is_open;
    assign o_out.door_b_open   = r_out_b.is_open;
    assign o_out.manual_mode   = r_out_manual;
    assign o_out.event_a       = r_out_ev_a;
    assign o_out.event_b       = r_out_ev_b;

endmodule

### hw/rtl/thdc_checker.sv
// ----------------------------------------------------------------------------
// thdc_checker
// Port-level assertions for the two-door hysteresis controller, bound to top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_door_hysteresis_controller_top_assert.svh"

module thdc_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  thdc_pkg::t_drive  i_drive_a,
    input  thdc_pkg::t_drive  i_drive_b,
    input  logic              i_open_a,
    input  logic              i_open_b,
    input  thdc_pkg::t_event  i_event_a,
    input  thdc_pkg::t_event  i_event_b
);
    import thdc_pkg::*;

    // a pending result stays until taken
    `THDC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // no undefined drive code on a valid result
    `THDC_ASSERT_RST(a_drive_code, i_clk, i_rst_n, i_out_valid |-> (i_drive_a != 2'd3 && i_drive_b != 2'd3))

    // last event on a door matches its reported flag and drive
    `THDC_ASSERT_RST(a_event_a, i_clk, i_rst_n, i_out_valid && i_event_a != EV_NONE |-> ((i_event_a == EV_OPENED && i_open_a && i_drive_a == DRV_OPEN) || (i_event_a == EV_CLOSED && !i_open_a && i_drive_a == DRV_CLOSE)))

    `THDC_ASSERT_RST(a_event_b, i_clk, i_rst_n, i_out_valid && i_event_b != EV_NONE |-> ((i_event_b == EV_OPENED && i_open_b && i_drive_b == DRV_OPEN) || (i_event_b == EV_CLOSED && !i_open_b && i_drive_b == DRV_CLOSE)))

    // no result straight out of reset
    `THDC_ASSERT_CLK(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind two_door_hysteresis_controller_top thdc_checker u_thdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_drive_a   (o_out.motor_a_drive),
    .i_drive_b   (o_out.motor_b_drive),
    .i_open_a    (o_out.door_a_open),
    .i_open_b    (o_out.door_b_open),
    .i_event_a   (o_out.event_a),
    .i_event_b   (o_out.event_b)
);
